[design/mouse_packet_decoder_with_fifo_assert.svh]
// assertion macros shared by the mouse packet decoder modules
`ifndef MOUSE_PACKET_DECODER_WITH_FIFO_ASSERT_SVH
`define MOUSE_PACKET_DECODER_WITH_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/mpd_pkg.sv]
// shared constants and types of the mouse packet decoder with receive fifo
package mpd_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = (FIFO_DEPTH > 2) ? $clog2(FIFO_DEPTH) : 1;

    localparam int BYTE_W   = 8;
    localparam int MOTION_W = 16;
    localparam int STEP_W   = 4;

    // apb register map
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam logic [1:0] REG_HEADER_MIN = 2'd0;
    localparam logic [1:0] REG_CLICK_CODE = 2'd1;
    localparam logic [1:0] REG_Y_STEP     = 2'd2;

    // register reset values
    localparam logic [BYTE_W-1:0] HEADER_MIN_RST = 8'd248;
    localparam logic [BYTE_W-1:0] CLICK_CODE_RST = 8'd250;
    localparam logic [STEP_W-1:0] Y_STEP_RST     = 4'd2;

    // request kinds carried on tuser
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic [BYTE_W-1:0] data;
    } fifo_cmd_t;

    typedef struct packed {
        logic has_data;
        logic has_data_next;
        logic pop_hit;
    } fifo_stat_t;

    typedef struct packed {
        logic signed [MOTION_W-1:0] x;
        logic signed [MOTION_W-1:0] y;
        logic                       click;
    } mouse_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_min;
        logic [BYTE_W-1:0] click_code;
        logic [STEP_W-1:0] y_step;
    } mpd_cfg_t;

endpackage

[design/mpd_fifo.sv]
// ring fifo of received bytes in a synchronous memory, one slot kept spare
module mpd_fifo (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  mpd_pkg::fifo_cmd_t        cmd_i,
    output mpd_pkg::fifo_stat_t       stat_o,
    output logic [mpd_pkg::BYTE_W-1:0] rd_data_o
);
    import mpd_pkg::*;

    `include "mouse_packet_decoder_with_fifo_assert.svh"

    logic [BYTE_W-1:0] byte_mem [FIFO_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_inc, rd_ptr_inc;
    logic              empty;
    logic              full;

    // ring increments
    assign wr_ptr_inc = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_inc == rd_ptr_reg);

    // pointer updates, a push into a full fifo is dropped
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (cmd_i.push && !full) begin
            wr_ptr_next = wr_ptr_inc;
        end
        if (cmd_i.pop && !empty) begin
            rd_ptr_next = rd_ptr_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // memory write port
    always_ff @(posedge aclk) begin
        if (cmd_i.push) begin
            byte_mem[wr_ptr_reg] <= cmd_i.data;
        end
    end

    // memory read port, data registered at the pop
    always_ff @(posedge aclk) begin
        if (cmd_i.pop && !empty) begin
            rd_data_reg <= byte_mem[rd_ptr_reg];
        end
    end

    assign rd_data_o            = rd_data_reg;
    assign stat_o.has_data      = !empty;
    assign stat_o.has_data_next = (wr_ptr_next != rd_ptr_next);
    assign stat_o.pop_hit       = cmd_i.pop && !empty;

    `ASSERT_NEXT(a_push_leaves_data, aclk, aresetn, cmd_i.push, wr_ptr_reg != rd_ptr_reg)
    `ASSERT_NEXT(a_empty_pop_holds, aclk, aresetn, cmd_i.pop && empty, rd_ptr_reg == $past(rd_ptr_reg))
    `ASSERT_IMPLIES(a_no_push_pop_same, aclk, aresetn, cmd_i.push, !cmd_i.pop)

endmodule

[design/mpd_decoder.sv]
// three-phase mouse packet decoder with saturating motion accumulators
module mpd_decoder (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_valid_i,
    input  logic [mpd_pkg::BYTE_W-1:0] byte_i,
    input  mpd_pkg::mpd_cfg_t      cfg_i,
    output mpd_pkg::mouse_state_t  cur_o,
    output mpd_pkg::mouse_state_t  nxt_o
);
    import mpd_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_X      = 2'd1;
    localparam logic [1:0] PH_Y      = 2'd2;

    logic [1:0]                 phase_reg, phase_next;
    logic signed [MOTION_W-1:0] x_reg, x_next;
    logic signed [MOTION_W-1:0] y_reg, y_next;
    logic                       click_reg, click_next;
    logic                       positive;
    logic signed [MOTION_W:0]   x_sum, y_sum, x_delta, y_delta;
    logic signed [MOTION_W-1:0] x_sat, y_sat;

    // positive means 1..127 as a signed byte
    assign positive = (byte_i != '0) && !byte_i[BYTE_W-1];
    assign x_delta  = positive ? (MOTION_W+1)'(1) : '1;
    assign y_delta  = positive ? (MOTION_W+1)'(cfg_i.y_step) : '1;
    assign x_sum    = {x_reg[MOTION_W-1], x_reg} + x_delta;
    assign y_sum    = {y_reg[MOTION_W-1], y_reg} + y_delta;

    // clamp on overflow of the 16-bit range
    assign x_sat = (x_sum[MOTION_W] != x_sum[MOTION_W-1])
                 ? {x_sum[MOTION_W], {(MOTION_W-1){~x_sum[MOTION_W]}}}
                 : x_sum[MOTION_W-1:0];
    assign y_sat = (y_sum[MOTION_W] != y_sum[MOTION_W-1])
                 ? {y_sum[MOTION_W], {(MOTION_W-1){~y_sum[MOTION_W]}}}
                 : y_sum[MOTION_W-1:0];

    // phase sequencing
    always_comb begin
        phase_next = phase_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        click_next = click_reg;
        if (byte_valid_i) begin
            case (phase_reg)
                PH_X: begin
                    x_next     = x_sat;
                    phase_next = PH_Y;
                end
                PH_Y: begin
                    y_next     = y_sat;
                    phase_next = PH_HEADER;
                end
                default: begin
                    if (byte_i >= cfg_i.header_min) begin
                        if (byte_i == cfg_i.click_code) begin
                            click_next = 1'b1;
                        end
                        phase_next = PH_X;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            x_reg     <= '0;
            y_reg     <= '0;
            click_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            click_reg <= click_next;
        end
    end

    assign cur_o.x     = x_reg;
    assign cur_o.y     = y_reg;
    assign cur_o.click = click_reg;
    assign nxt_o.x     = x_next;
    assign nxt_o.y     = y_next;
    assign nxt_o.click = click_next;

endmodule

[design/mouse_packet_decoder_with_fifo.sv]
// Top level: receive byte fifo and mouse packet decoder behind stream ports.
// A received-byte word has its result registered at the accept edge.
// A read word waits in ST_READ for the registered fifo memory read before its result loads.
// One word in flight at a time; a new word is taken while the result register drains.
// Reset (aresetn, synchronous, active low) empties the fifo and clears decoder state.
module mouse_packet_decoder_with_fifo (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mpd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mpd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mpd_pkg::APB_DATA_W-1:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic        s_tuser,   // [0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [7:0] read_byte, [8] fifo_has_data, [24:9] motion_x,
                                   // [40:25] motion_y, [41] click_seen, [47:42] zero
);
    import mpd_pkg::*;

    `include "mouse_packet_decoder_with_fifo_assert.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic              state_reg, state_next;
    mpd_cfg_t          cfg_reg, cfg_next;
    logic              out_valid_reg, out_valid_next;
    logic [47:0]       out_data_reg, out_data_next;
    logic              pop_hit_reg;
    logic              s_accept;
    logic              apb_write;
    logic              out_load;
    fifo_cmd_t         fifo_cmd;
    fifo_stat_t        fifo_stat;
    logic [BYTE_W-1:0] fifo_rd_data;
    mouse_state_t      mouse_cur, mouse_nxt;
    logic [BYTE_W-1:0] rsp_byte;
    logic              rsp_has_data;
    mouse_state_t      rsp_mouse;

    // apb register file
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (apb_write) begin
            case (paddr[3:2])
                REG_HEADER_MIN: cfg_next.header_min = pwdata[BYTE_W-1:0];
                REG_CLICK_CODE: cfg_next.click_code = pwdata[BYTE_W-1:0];
                REG_Y_STEP:     cfg_next.y_step     = pwdata[STEP_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HEADER_MIN: prdata = APB_DATA_W'(cfg_reg.header_min);
            REG_CLICK_CODE: prdata = APB_DATA_W'(cfg_reg.click_code);
            REG_Y_STEP:     prdata = APB_DATA_W'(cfg_reg.y_step);
            default:        prdata = '0;
        endcase
    end

    // input handshake and fifo / decoder commands
    assign s_tready      = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign s_accept      = s_tvalid && s_tready;
    assign fifo_cmd.push = s_accept && (s_tuser == REQ_BYTE) && (s_tdata != '0);
    assign fifo_cmd.pop  = s_accept && (s_tuser == REQ_READ);
    assign fifo_cmd.data = s_tdata;

    mpd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (fifo_cmd),
        .stat_o    (fifo_stat),
        .rd_data_o (fifo_rd_data)
    );

    mpd_decoder u_decoder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_valid_i (fifo_cmd.push),
        .byte_i       (s_tdata),
        .cfg_i        (cfg_reg),
        .cur_o        (mouse_cur),
        .nxt_o        (mouse_nxt)
    );

    // result assembly: byte words now, read words once memory data returns
    always_comb begin
        state_next   = state_reg;
        out_load     = 1'b0;
        rsp_byte     = '0;
        rsp_has_data = fifo_stat.has_data_next;
        rsp_mouse    = mouse_nxt;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == REQ_READ) begin
                        state_next = ST_READ;
                    end else begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_READ: begin
                out_load     = 1'b1;
                rsp_byte     = pop_hit_reg ? fifo_rd_data : '0;
                rsp_has_data = fifo_stat.has_data;
                rsp_mouse    = mouse_cur;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output register
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);
    assign out_data_next  = out_load
                          ? {6'd0, rsp_mouse.click, rsp_mouse.y, rsp_mouse.x,
                             rsp_has_data, rsp_byte}
                          : out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{header_min: HEADER_MIN_RST, click_code: CLICK_CODE_RST,
                               y_step: Y_STEP_RST};
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        pop_hit_reg  <= fifo_stat.pop_hit;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `ASSERT_IMPLIES(a_read_slot_free, aclk, aresetn, state_reg == ST_READ, !out_valid_reg)
    `ASSERT_NEXT(a_read_waits, aclk, aresetn, fifo_cmd.pop, state_reg == ST_READ)
    `ASSERT_NEXT(a_byte_result, aclk, aresetn, s_accept && s_tuser == REQ_BYTE, out_valid_reg)

endmodule

[tb/mouse_packet_decoder_with_fifo_test.sv]
// self-checking testbench for the mouse packet decoder with receive fifo
`timescale 1ns / 1ps

module mouse_packet_decoder_with_fifo_test;
    import mpd_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef enum logic [1:0] {
        WAIT_HEADER = 2'd0,
        WANT_X      = 2'd1,
        WANT_Y      = 2'd2
    } pkt_phase_t;

    // result word layout, lowest field last
    typedef struct packed {
        logic                       click_seen;
        logic signed [MOTION_W-1:0] motion_y;
        logic signed [MOTION_W-1:0] motion_x;
        logic                       fifo_has_data;
        logic [BYTE_W-1:0]          read_byte;
    } report_t;

    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] data;
        bit                hold;
    } word_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] scan_byte
    logic        s_tuser  = 1'b0; // [0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [7:0] read_byte, [8] fifo_has_data, [24:9] motion_x,
                                  // [40:25] motion_y, [41] click_seen, [47:42] zero

    mouse_packet_decoder_with_fifo dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // predictor state and register mirror
    logic [BYTE_W-1:0]          ring_mem [FIFO_DEPTH];
    int                         wr_pos;
    int                         rd_pos;
    pkt_phase_t                 pkt_phase;
    logic signed [MOTION_W-1:0] x_acc;
    logic signed [MOTION_W-1:0] y_acc;
    logic                       click_flag_q;
    mpd_cfg_t                   cfg_mirror;

    word_t   pending_words [$];
    report_t expected_reports [$];
    word_t   next_word;
    report_t mon_got;
    report_t mon_want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    function automatic int ring_next(input int i);
        return (i + 1 >= FIFO_DEPTH) ? 0 : i + 1;
    endfunction

    function automatic logic signed [MOTION_W-1:0] clamp16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[MOTION_W-1:0];
    endfunction

    // one accepted word through the fifo and the packet decoder
    function automatic report_t step_decoder_fifo(input logic kind, input logic [7:0] b);
        report_t r;
        int      nxt;
        bit      positive;
        r = '0;
        positive = (b >= 8'd1 && b <= 8'd127);
        if (kind == REQ_READ) begin
            if (wr_pos != rd_pos) begin
                r.read_byte = ring_mem[rd_pos];
                rd_pos = ring_next(rd_pos);
            end
        end else if (b != 8'd0) begin
            case (pkt_phase)
                WANT_X: begin
                    x_acc = clamp16(int'(x_acc) + (positive ? 1 : -1));
                    pkt_phase = WANT_Y;
                end
                WANT_Y: begin
                    y_acc = clamp16(int'(y_acc) + (positive ? int'(cfg_mirror.y_step) : -1));
                    pkt_phase = WAIT_HEADER;
                end
                default: begin
                    if (b >= cfg_mirror.header_min) begin
                        if (b == cfg_mirror.click_code)
                            click_flag_q = 1'b1;
                        pkt_phase = WANT_X;
                    end
                end
            endcase
            // a full fifo takes the byte into the spare slot and drops it
            ring_mem[wr_pos] = b;
            nxt = ring_next(wr_pos);
            if (nxt != rd_pos)
                wr_pos = nxt;
        end
        r.fifo_has_data = (wr_pos != rd_pos);
        r.motion_x      = x_acc;
        r.motion_y      = y_acc;
        r.click_seen    = click_flag_q;
        return r;
    endfunction

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
            log_failure($sformatf("%s mismatch: expected %h, actual %h", name, exp_v, act_v));
    endtask

    function automatic void add_word(input logic kind, input logic [7:0] data);
        pending_words.push_back('{kind, data, 1'b0});
    endfunction

    // apb write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEADER_MIN: cfg_mirror.header_min = value[BYTE_W-1:0];
            REG_CLICK_CODE: cfg_mirror.click_code = value[BYTE_W-1:0];
            REG_Y_STEP:     cfg_mirror.y_step     = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int hmin, input int click, input int step,
                             input int idle, input int stall);
        write_reg(REG_HEADER_MIN, hmin);
        write_reg(REG_CLICK_CODE, click);
        write_reg(REG_Y_STEP, step);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || expected_reports.size() != 0);
    endtask

    // mostly well-formed packets, with read bursts, push bursts and noise
    task automatic queue_random(input int target);
        int          made;
        int          pick;
        int          n;
        int          base;
        logic [7:0]  hdr;
        logic        kind;
        logic [7:0]  data;
        made = 0;
        base = pending_words.size();
        while (made < target) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if (cfg_mirror.header_min == 8'd0)
                    hdr = $urandom_range(255, 1);
                else
                    hdr = $urandom_range(255, cfg_mirror.header_min);
                if ($urandom_range(3) == 0 && cfg_mirror.click_code != 8'd0
                        && cfg_mirror.click_code >= cfg_mirror.header_min)
                    hdr = cfg_mirror.click_code;
                add_word(REQ_BYTE, hdr);
                add_word(REQ_BYTE, $urandom_range(255, 1));
                add_word(REQ_BYTE, $urandom_range(255, 1));
                made += 3;
            end else if (pick < 75) begin
                n = $urandom_range(16, 1);
                repeat (n) add_word(REQ_READ, $urandom_range(255));
                made += n;
            end else if (pick < 83) begin
                n = $urandom_range(20, 6);
                repeat (n) add_word(REQ_BYTE, $urandom_range(255, 1));
                made += n;
            end else begin
                kind = $urandom_range(1);
                data = $urandom_range(255);
                add_word(kind, data);
                if (kind == REQ_READ || data != 8'd0)
                    made++;
            end
        end
        // sender waits for every result before this word
        pending_words[base + (pending_words.size() - base) / 2].hold = 1'b1;
    endtask

    // packet runs that push the x total up and the y total down, then the reverse
    task automatic queue_saturation();
        if (pkt_phase == WANT_X)
            add_word(REQ_BYTE, 8'd5);
        if (pkt_phase != WAIT_HEADER)
            add_word(REQ_BYTE, 8'd5);
        for (int i = 0; i < 20; i++) begin
            add_word(REQ_BYTE, $urandom_range(255, 248));
            add_word(REQ_BYTE, $urandom_range(127, 1));
            add_word(REQ_BYTE, $urandom_range(255, 128));
            if (i % 8 == 0)
                add_word(REQ_READ, $urandom_range(255));
        end
        for (int i = 0; i < 20; i++) begin
            add_word(REQ_BYTE, $urandom_range(255, 248));
            add_word(REQ_BYTE, $urandom_range(255, 128));
            add_word(REQ_BYTE, $urandom_range(127, 1));
            if (i % 8 == 0)
                add_word(REQ_READ, $urandom_range(255));
        end
        pending_words[pending_words.size() / 2].hold = 1'b1;
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(step_decoder_fifo(s_tuser, s_tdata));
                words_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0
                        && !(pending_words[0].hold && words_sent != results_seen)
                        && $urandom_range(99) >= send_idle_pct) begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_word.data;
                    s_tuser  <= next_word.kind;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            mon_got = m_tdata[41:0];
            if (expected_reports.size() == 0) begin
                log_failure($sformatf("result word with nothing expected: %h", m_tdata));
            end else begin
                mon_want = expected_reports.pop_front();
                check_field("read_byte", 16'(mon_want.read_byte), 16'(mon_got.read_byte));
                check_field("fifo_has_data", 16'(mon_want.fifo_has_data),
                            16'(mon_got.fifo_has_data));
                check_field("motion_x", mon_want.motion_x, mon_got.motion_x);
                check_field("motion_y", mon_want.motion_y, mon_got.motion_y);
                check_field("click_seen", 16'(mon_want.click_seen), 16'(mon_got.click_seen));
            end
        end
    end

    // run timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        wr_pos       = 0;
        rd_pos       = 0;
        pkt_phase    = WAIT_HEADER;
        x_acc        = '0;
        y_acc        = '0;
        click_flag_q = 1'b0;
        cfg_mirror.header_min = HEADER_MIN_RST;
        cfg_mirror.click_code = CLICK_CODE_RST;
        cfg_mirror.y_step     = Y_STEP_RST;
        for (int i = 0; i < FIFO_DEPTH; i++)
            ring_mem[i] = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed words under the reset register values
        add_word(REQ_READ, 8'hFF);   // read of an empty fifo
        add_word(REQ_BYTE, 8'h00);   // zero byte is ignored
        add_word(REQ_BYTE, 8'd5);    // below header while waiting, pushed only
        add_word(REQ_BYTE, 8'd248);  // header at the minimum
        add_word(REQ_BYTE, 8'd1);
        add_word(REQ_BYTE, 8'd127);
        add_word(REQ_BYTE, 8'd250);  // left-click header
        add_word(REQ_BYTE, 8'd128);
        add_word(REQ_BYTE, 8'd255);
        add_word(REQ_BYTE, 8'd255);
        add_word(REQ_BYTE, 8'd127);
        add_word(REQ_BYTE, 8'd128);
        add_word(REQ_BYTE, 8'd249);
        add_word(REQ_BYTE, 8'h00);   // zero in the middle of a packet
        add_word(REQ_BYTE, 8'd255);
        add_word(REQ_BYTE, 8'd1);
        repeat (6) add_word(REQ_READ, 8'h00);
        queue_random(150);
        wait_drained();

        configure(0, 0, 15, 67, 0);
        queue_random(150);
        wait_drained();

        configure(255, 255, 0, 0, 67);
        queue_random(150);
        wait_drained();

        // click code under the header minimum never sets the flag
        configure(200, 100, 7, 9, 9);
        add_word(REQ_BYTE, 8'd100);
        add_word(REQ_BYTE, 8'd199);
        queue_random(150);
        wait_drained();

        configure(128, 128, 1, 0, 0);
        queue_random(150);
        wait_drained();

        configure($urandom_range(255), $urandom_range(255), $urandom_range(15), 67, 0);
        queue_random(150);
        wait_drained();

        configure($urandom_range(255), $urandom_range(255), $urandom_range(15), 0, 67);
        queue_random(150);
        wait_drained();

        configure($urandom_range(255), $urandom_range(255), $urandom_range(15), 9, 9);
        queue_random(150);
        wait_drained();

        configure(248, 250, 15, 0, 0);
        queue_saturation();
        wait_drained();

        // let any stray word show up
        repeat (10) @(posedge aclk);
        if (expected_reports.size() != 0)
            log_failure($sformatf("%0d results never arrived", expected_reports.size()));
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
